FILE: sv/pwmt_pkg.sv
// ----------------------------------------------------------------------------
// pwmt_pkg
// Shared types and constants for the dead-time PWM timer.
// ----------------------------------------------------------------------------
package pwmt_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_ACK   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        REG_CNT   = 4'd0,
        REG_HIGH  = 4'd1,
        REG_OCRA  = 4'd2,
        REG_OCRB  = 4'd3,
        REG_OCRC  = 4'd4,
        REG_OCRD  = 4'd5,
        REG_CTLA  = 4'd6,
        REG_CTLB  = 4'd7,
        REG_CTLC  = 4'd8,
        REG_CTLD  = 4'd9,
        REG_CTLE  = 4'd10,
        REG_DT    = 4'd11,
        REG_MASK  = 4'd12,
        REG_FLAGS = 4'd13,
        REG_PLL   = 4'd14,
        REG_NONE  = 4'd15
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_STEP = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    localparam logic [7:0] FLAG_A   = 8'h40;
    localparam logic [7:0] FLAG_B   = 8'h20;
    localparam logic [7:0] FLAG_D   = 8'h80;
    localparam logic [7:0] FLAG_OVF = 8'h04;
    localparam logic [7:0] PLL_READ_MASK = 8'hF6;

    // controller to datapath
    typedef struct packed {
        logic start;   // latch item, do item-level work
        logic step;    // one counter step
        logic finish;  // capture result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic steps_left;
    } status_t;

endpackage

FILE: sv/pwmt_ctrl.sv
// ----------------------------------------------------------------------------
// pwmt_ctrl
// Sequencer: accepts a transaction, runs counter steps, hands off a result.
// ----------------------------------------------------------------------------
module pwmt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              out_free,
    input  pwmt_pkg::status_t sts,
    output pwmt_pkg::cmd_t    cmd
);
    import pwmt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_STEP;
            end
            ST_STEP: begin
                if (!sts.steps_left) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.start  = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            ST_STEP: begin
                cmd.step = sts.steps_left;
            end
            ST_DONE: begin
                cmd.finish = out_free;
            end
            default: ;
        endcase
    end
endmodule

FILE: sv/pwmt_dp.sv
// ----------------------------------------------------------------------------
// pwmt_dp
// Timer datapath: registers, prescaler, counter step unit, outputs.
// ----------------------------------------------------------------------------
module pwmt_dp #(
    parameter int COUNTER_BITS    = 10,
    parameter int PLL_LOCK_CYCLES = 100
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic [1:0]        s_action,
    input  logic [3:0]        s_reg_index,
    input  logic [7:0]        s_write_data,
    input  logic [1:0]        s_ack_source,
    input  logic              s_powered_down,
    input  pwmt_pkg::cmd_t    cmd,
    output pwmt_pkg::status_t sts,
    output logic              out_free,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [7:0]        m_rdata,
    output logic [5:0]        m_pin_levels,
    output logic              m_irq_pending,
    output logic [1:0]        m_irq_source,
    output logic [3:0]        m_adc_triggers
);
    import pwmt_pkg::*;

    localparam int CB = COUNTER_BITS;

    logic [7:0]    csmask_reg;
    logic [CB-1:0] cnt_reg;
    logic [1:0]    high_reg;
    logic [CB-1:0] act_reg [4];
    logic [CB-1:0] buf_reg [4];
    logic [7:0]    ctl_reg [5];
    logic [7:0]    dt_reg, mask_reg, flags_reg, pll_reg;
    logic [6:0]    lock_cnt_reg;
    logic          locked_reg;
    logic [3:0]    dtc_reg [6];
    logic          up_reg;
    logic [10:0]   acc_reg;
    logic [5:0]    pins_reg;
    logic [3:0]    trig_reg;
    logic [10:0]   nsteps_reg;
    logic [7:0]    rd_reg;

    // clock select and prescaler
    logic [7:0]  cs;
    logic [10:0] acc_sum, acc_mod;
    logic [10:0] n_steps;
    logic [CB-1:0] wide;

    assign cs   = ctl_reg[1] & csmask_reg;
    assign wide = CB'({high_reg, s_write_data});

    // leftover count from a larger divider is spent in full
    always_comb begin
        acc_sum = acc_reg + (pll_reg[2] ? 11'd8 : 11'd1);
        acc_mod = acc_sum;
        n_steps = '0;
        unique case (cs)
            8'd1: begin n_steps = acc_sum; acc_mod = '0; end
            8'd2: begin n_steps = {3'd0, acc_sum[10:3]}; acc_mod = {8'd0, acc_sum[2:0]}; end
            8'd3: begin n_steps = {6'd0, acc_sum[10:6]}; acc_mod = {5'd0, acc_sum[5:0]}; end
            8'd4: begin n_steps = {8'd0, acc_sum[10:8]}; acc_mod = {3'd0, acc_sum[7:0]}; end
            8'd5: begin n_steps = {10'd0, acc_sum[10]}; acc_mod = {1'b0, acc_sum[9:0]}; end
            default: begin n_steps = '0; acc_mod = acc_reg; end
        endcase
    end

    assign sts.steps_left = (nsteps_reg != '0);

    // one counter step, combinational
    logic [CB-1:0] st_cnt;
    logic          st_up;
    logic [5:0]    st_pins;
    logic [3:0]    st_dtc [6];
    logic [7:0]    st_flags;
    logic [3:0]    st_trig;
    logic          st_load;
    logic          pfc;
    logic [1:0]    com [3];
    logic [3:0]    dt_t, dt_n;

    assign pfc  = (ctl_reg[3][1:0] == 2'd1);
    assign com[0] = ctl_reg[0][7:6];
    assign com[1] = ctl_reg[0][5:4];
    assign com[2] = ctl_reg[3][5:4];
    assign dt_t = dt_reg[3:0];
    assign dt_n = dt_reg[7:4];

    always_comb begin
        logic [CB-1:0] nc;
        logic          hit [3];
        logic          drv_hi;
        logic          ovf;
        st_pins  = pins_reg;
        st_flags = flags_reg;
        st_trig  = trig_reg;
        st_up    = up_reg;
        st_load  = 1'b0;
        ovf      = 1'b0;
        for (int i = 0; i < 6; i++) begin
            st_dtc[i] = dtc_reg[i];
            if (dtc_reg[i] != 4'd0) begin
                st_dtc[i] = dtc_reg[i] - 4'd1;
                if (dtc_reg[i] == 4'd1) st_pins[i] = 1'b1;
            end
        end
        nc = up_reg ? cnt_reg + 1'b1 : cnt_reg - 1'b1;
        if (up_reg && nc >= act_reg[2]) begin
            if (pfc) begin
                st_up = 1'b0;
            end else begin
                ovf = 1'b1;
                nc = '0;
                st_load = 1'b1;
            end
        end else if (!up_reg && nc == '0) begin
            ovf = 1'b1;
            st_up = 1'b1;
            st_load = 1'b1;
        end
        st_cnt = nc;
        hit[0] = (nc == act_reg[0]);
        hit[1] = (nc == act_reg[1]);
        hit[2] = (nc == act_reg[3]);
        if (ovf) begin
            st_flags = st_flags | FLAG_OVF;
            st_trig[3] = 1'b1;
        end
        for (int c = 0; c < 3; c++) begin
            drv_hi = 1'b0;
            if (ovf) begin
                drv_hi = (com[c] == 2'd2);
            end else begin
                drv_hi = (com[c] == 2'd2) ? !st_up : st_up;
                if (hit[c]) begin
                    st_trig[c] = 1'b1;
                    st_flags = st_flags | ((c == 0) ? FLAG_A : (c == 1) ? FLAG_B : FLAG_D);
                end
            end
            if (com[c][1] && ((ovf && !pfc) || (!st_load && hit[c]))) begin
                if (drv_hi) begin
                    st_pins[2*c+1] = 1'b0;
                    if (dt_t == 4'd0) st_pins[2*c] = 1'b1;
                    else st_dtc[2*c] = dt_t;
                end else begin
                    st_pins[2*c] = 1'b0;
                    if (dt_n == 4'd0) st_pins[2*c+1] = 1'b1;
                    else st_dtc[2*c+1] = dt_n;
                end
            end
        end
    end

    // interrupt priority
    logic [7:0] actv;
    assign actv = flags_reg & mask_reg;

    assign out_free = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csmask_reg   <= 8'd15;
            cnt_reg      <= '0;
            high_reg     <= '0;
            dt_reg       <= '0;
            mask_reg     <= '0;
            flags_reg    <= '0;
            pll_reg      <= '0;
            lock_cnt_reg <= '0;
            locked_reg   <= 1'b0;
            up_reg       <= 1'b1;
            acc_reg      <= '0;
            pins_reg     <= '0;
            trig_reg     <= '0;
            nsteps_reg   <= '0;
            rd_reg       <= '0;
            m_valid      <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                act_reg[i] <= '0;
                buf_reg[i] <= '0;
            end
            for (int i = 0; i < 5; i++) ctl_reg[i] <= '0;
            for (int i = 0; i < 6; i++) dtc_reg[i] <= '0;
        end else begin
            if (cfg_we) csmask_reg <= cfg_wdata;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cmd.start) begin
                trig_reg <= '0;
                rd_reg   <= '0;
                unique case (action_t'(s_action))
                    ACT_TICK: begin
                        if (!s_powered_down) begin
                            if (pll_reg[1]) begin
                                if (!locked_reg) begin
                                    if (lock_cnt_reg == '0)
                                        lock_cnt_reg <= 7'(PLL_LOCK_CYCLES);
                                    else if (lock_cnt_reg == 7'd1) begin
                                        lock_cnt_reg <= '0;
                                        locked_reg   <= 1'b1;
                                    end else lock_cnt_reg <= lock_cnt_reg - 7'd1;
                                end
                            end else begin
                                locked_reg   <= 1'b0;
                                lock_cnt_reg <= '0;
                            end
                            acc_reg    <= acc_mod;
                            nsteps_reg <= n_steps;
                        end
                    end
                    ACT_READ: begin
                        unique case (reg_idx_t'(s_reg_index))
                            REG_CNT:   rd_reg <= cnt_reg[7:0];
                            REG_HIGH:  rd_reg <= {6'd0, high_reg};
                            REG_OCRA:  rd_reg <= buf_reg[0][7:0];
                            REG_OCRB:  rd_reg <= buf_reg[1][7:0];
                            REG_OCRC:  rd_reg <= buf_reg[2][7:0];
                            REG_OCRD:  rd_reg <= buf_reg[3][7:0];
                            REG_CTLA:  rd_reg <= ctl_reg[0];
                            REG_CTLB:  rd_reg <= ctl_reg[1];
                            REG_CTLC:  rd_reg <= ctl_reg[2];
                            REG_CTLD:  rd_reg <= ctl_reg[3];
                            REG_CTLE:  rd_reg <= ctl_reg[4];
                            REG_DT:    rd_reg <= dt_reg;
                            REG_MASK:  rd_reg <= mask_reg;
                            REG_FLAGS: rd_reg <= flags_reg;
                            REG_PLL: begin
                                if (lock_cnt_reg != '0 && !locked_reg
                                        && lock_cnt_reg <= 7'd5) begin
                                    lock_cnt_reg <= '0;
                                    locked_reg   <= 1'b1;
                                    rd_reg <= (pll_reg & PLL_READ_MASK) | 8'd1;
                                end else begin
                                    if (lock_cnt_reg != '0 && !locked_reg)
                                        lock_cnt_reg <= lock_cnt_reg - 7'd5;
                                    rd_reg <= (pll_reg & PLL_READ_MASK)
                                              | {7'd0, locked_reg};
                                end
                            end
                            default: rd_reg <= '0;
                        endcase
                    end
                    ACT_WRITE: begin
                        unique case (reg_idx_t'(s_reg_index))
                            REG_CNT:  cnt_reg <= wide;
                            REG_HIGH: high_reg <= s_write_data[1:0];
                            REG_OCRA: begin
                                buf_reg[0] <= wide;
                                if (ctl_reg[0][1:0] == 2'd0) act_reg[0] <= wide;
                            end
                            REG_OCRB: begin
                                buf_reg[1] <= wide;
                                if (ctl_reg[0][1:0] == 2'd0) act_reg[1] <= wide;
                            end
                            REG_OCRC: begin
                                buf_reg[2] <= wide;
                                act_reg[2] <= wide;
                            end
                            REG_OCRD: begin
                                buf_reg[3] <= wide;
                                if (ctl_reg[3][1:0] == 2'd0) act_reg[3] <= wide;
                            end
                            REG_CTLA:  ctl_reg[0] <= s_write_data;
                            REG_CTLB:  ctl_reg[1] <= s_write_data;
                            REG_CTLC:  ctl_reg[2] <= s_write_data;
                            REG_CTLD:  ctl_reg[3] <= s_write_data;
                            REG_CTLE:  ctl_reg[4] <= s_write_data;
                            REG_DT:    dt_reg <= s_write_data;
                            REG_MASK:  mask_reg <= s_write_data;
                            REG_FLAGS: flags_reg <= flags_reg & ~s_write_data;
                            REG_PLL: begin
                                pll_reg <= s_write_data;
                                if (s_write_data[1]) begin
                                    if (!locked_reg && lock_cnt_reg == '0)
                                        lock_cnt_reg <= 7'(PLL_LOCK_CYCLES);
                                end else begin
                                    locked_reg   <= 1'b0;
                                    lock_cnt_reg <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    ACT_ACK: begin
                        unique case (s_ack_source)
                            2'd0: flags_reg <= flags_reg & ~FLAG_A;
                            2'd1: flags_reg <= flags_reg & ~FLAG_B;
                            2'd2: flags_reg <= flags_reg & ~FLAG_D;
                            default: flags_reg <= flags_reg & ~FLAG_OVF;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (cmd.step) begin
                nsteps_reg <= nsteps_reg - 11'd1;
                cnt_reg    <= st_cnt;
                up_reg     <= st_up;
                pins_reg   <= st_pins;
                flags_reg  <= st_flags;
                trig_reg   <= st_trig;
                for (int i = 0; i < 6; i++) dtc_reg[i] <= st_dtc[i];
                if (st_load) begin
                    act_reg[0] <= buf_reg[0];
                    act_reg[1] <= buf_reg[1];
                    act_reg[3] <= buf_reg[3];
                end
            end
            if (cmd.finish) begin
                m_valid        <= 1'b1;
                m_rdata        <= rd_reg;
                m_pin_levels   <= pins_reg;
                m_adc_triggers <= trig_reg;
                m_irq_pending  <= (actv & (FLAG_A | FLAG_B | FLAG_D | FLAG_OVF)) != 8'd0;
                if (actv[6])      m_irq_source <= 2'd0;
                else if (actv[5]) m_irq_source <= 2'd1;
                else if (actv[7]) m_irq_source <= 2'd2;
                else if (actv[2]) m_irq_source <= 2'd3;
                else              m_irq_source <= 2'd0;
            end
        end
    end
endmodule

FILE: sv/pwm_timer_with_dead_time.sv
// ----------------------------------------------------------------------------
// pwm_timer_with_dead_time
// 10-bit high-speed PWM timer with byte register access and dead time.
// ----------------------------------------------------------------------------
// each transaction is a cpu tick, register read, register write or interrupt
// acknowledge and yields exactly one result transaction. the controller takes
// a transaction in idle, runs its counter steps in the step state and registers
// the result in the done state once the output register is free, then goes
// back to idle for the next transaction. steps run one per cycle through the
// single shared step unit in the datapath: with the pll clock and prescale of
// one a tick gives eight steps, and when the clock select drops from a large
// divider to a small one the leftover prescaler count is spent by the next
// tick, up to 1031 steps. a new transaction can be taken while the previous
// result still waits in the output register; its own result is then held
// until that register is free. cfg_we writes the clock select mask.
module pwm_timer_with_dead_time #(
    parameter int COUNTER_BITS    = 10,
    parameter int PLL_LOCK_CYCLES = 100
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [3:0] s_reg_index,
    input  logic [7:0] s_write_data,
    input  logic [1:0] s_ack_source,
    input  logic       s_powered_down,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_rdata,
    output logic [5:0] m_pin_levels,
    output logic       m_irq_pending,
    output logic [1:0] m_irq_source,
    output logic [3:0] m_adc_triggers
);
    import pwmt_pkg::*;

    // controller/datapath handshake
    cmd_t    cmd;
    status_t sts;
    logic    out_free;

    pwmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    pwmt_dp #(
        .COUNTER_BITS    (COUNTER_BITS),
        .PLL_LOCK_CYCLES (PLL_LOCK_CYCLES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_action       (s_action),
        .s_reg_index    (s_reg_index),
        .s_write_data   (s_write_data),
        .s_ack_source   (s_ack_source),
        .s_powered_down (s_powered_down),
        .cmd            (cmd),
        .sts            (sts),
        .out_free       (out_free),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_rdata        (m_rdata),
        .m_pin_levels   (m_pin_levels),
        .m_irq_pending  (m_irq_pending),
        .m_irq_source   (m_irq_source),
        .m_adc_triggers (m_adc_triggers)
    );
endmodule

FILE: bench/pwm_timer_with_dead_time_tb.sv
// ----------------------------------------------------------------------------
// pwm_timer_with_dead_time_tb
// Self-checking bench: random register, tick and acknowledge transactions
// against a cycle-free predictor of the timer, under several idling phases.
// ----------------------------------------------------------------------------
module pwm_timer_with_dead_time_tb;
    import pwmt_pkg::*;

    localparam int CNT_BITS  = 10;
    localparam int LOCK_CYC  = 100;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        action_t    action;
        reg_idx_t   idx;
        logic [7:0] wdata;
        logic [1:0] ack;
        logic       pd;
    } txn_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic [5:0] pins;
        logic       pend;
        logic [1:0] src;
        logic [3:0] trig;
    } res_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_action = 2'd0;
    logic [3:0] s_reg_index = 4'd0;
    logic [7:0] s_write_data = 8'd0;
    logic [1:0] s_ack_source = 2'd0;
    logic       s_powered_down = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_rdata;
    logic [5:0] m_pin_levels;
    logic       m_irq_pending;
    logic [1:0] m_irq_source;
    logic [3:0] m_adc_triggers;

    always #1 aclk = ~aclk;

    pwm_timer_with_dead_time #(.COUNTER_BITS(CNT_BITS), .PLL_LOCK_CYCLES(LOCK_CYC)) i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_reg_index(s_reg_index), .s_write_data(s_write_data),
        .s_ack_source(s_ack_source), .s_powered_down(s_powered_down),
        .m_valid(m_valid), .m_ready(m_ready), .m_rdata(m_rdata),
        .m_pin_levels(m_pin_levels), .m_irq_pending(m_irq_pending),
        .m_irq_source(m_irq_source), .m_adc_triggers(m_adc_triggers)
    );

    // ---------------- timer predictor state ----------------
    logic [7:0]  m_cs_mask;
    logic [9:0]  m_cnt;
    logic [1:0]  m_hi;
    logic [9:0]  m_cmp_act [4];
    logic [9:0]  m_cmp_buf [4];
    logic [7:0]  m_ctl [5];
    logic [7:0]  m_dt, m_mask, m_flags, m_pll;
    logic [6:0]  m_lock_cnt;
    logic        m_locked;
    logic [3:0]  m_dt_cnt [6];
    logic        m_up;
    logic [10:0] m_pre;
    logic [5:0]  m_pins;
    logic [3:0]  m_trig;

    res_t expected_q [$];

    int n_fail = 0;
    int n_checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_send = 1'b0;
    int wdog = 0;

    function automatic void timer_reset();
        m_cs_mask = 8'd15; m_cnt = '0; m_hi = '0;
        for (int i = 0; i < 4; i++) begin
            m_cmp_act[i] = '0; m_cmp_buf[i] = '0;
        end
        for (int i = 0; i < 5; i++) m_ctl[i] = '0;
        for (int i = 0; i < 6; i++) m_dt_cnt[i] = '0;
        m_dt = '0; m_mask = '0; m_flags = '0; m_pll = '0;
        m_lock_cnt = '0; m_locked = 1'b0; m_up = 1'b1; m_pre = '0;
        m_pins = '0; m_trig = '0;
    endfunction

    // drive the true pin or the inverted one, each after its own dead time
    function automatic void drive_pair(int ch, bit true_high);
        int t, n;
        logic [3:0] d;
        t = ch * 2;
        n = t + 1;
        if (true_high) begin
            m_pins[n] = 1'b0;
            d = m_dt[3:0];
            if (d == 0) m_pins[t] = 1'b1; else m_dt_cnt[t] = d;
        end else begin
            m_pins[t] = 1'b0;
            d = m_dt[7:4];
            if (d == 0) m_pins[n] = 1'b1; else m_dt_cnt[n] = d;
        end
    endfunction

    function automatic logic [1:0] out_mode(int ch);
        if (ch == 0) return m_ctl[0][7:6];
        if (ch == 1) return m_ctl[0][5:4];
        return m_ctl[3][5:4];
    endfunction

    function automatic void on_match(int ch);
        logic [1:0] com;
        com = out_mode(ch);
        case (ch)
            0: m_flags |= FLAG_A;
            1: m_flags |= FLAG_B;
            default: m_flags |= FLAG_D;
        endcase
        m_trig[ch] = 1'b1;
        if (com == 2'd2) drive_pair(ch, !m_up);
        else if (com == 2'd3) drive_pair(ch, m_up);
    endfunction

    function automatic void on_overflow();
        m_flags |= FLAG_OVF;
        m_trig[3] = 1'b1;
        if (m_ctl[3][1:0] != 2'd1) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (out_mode(ch) == 2'd2) drive_pair(ch, 1'b1);
                else if (out_mode(ch) == 2'd3) drive_pair(ch, 1'b0);
            end
        end
    endfunction

    function automatic void step_counter();
        bit loaded;
        bit pfc;
        loaded = 1'b0;
        pfc = (m_ctl[3][1:0] == 2'd1);
        for (int i = 0; i < 6; i++) begin
            if (m_dt_cnt[i] != 0) begin
                m_dt_cnt[i]--;
                if (m_dt_cnt[i] == 0) m_pins[i] = 1'b1;
            end
        end
        if (m_up) m_cnt = m_cnt + 10'd1; else m_cnt = m_cnt - 10'd1;
        if (m_up && m_cnt >= m_cmp_act[2]) begin
            if (pfc) m_up = 1'b0;
            else begin
                on_overflow();
                m_cnt = '0;
                loaded = 1'b1;
            end
        end else if (!m_up && m_cnt == 0) begin
            on_overflow();
            m_up = 1'b1;
            loaded = 1'b1;
        end
        if (loaded) begin
            m_cmp_act[0] = m_cmp_buf[0];
            m_cmp_act[1] = m_cmp_buf[1];
            m_cmp_act[3] = m_cmp_buf[3];
        end else begin
            if (m_cnt == m_cmp_act[0]) on_match(0);
            if (m_cnt == m_cmp_act[1]) on_match(1);
            if (m_cnt == m_cmp_act[3]) on_match(2);
        end
    endfunction

    function automatic void cpu_tick();
        logic [7:0] cs;
        int divisor, steps;
        if (m_pll[1]) begin
            if (!m_locked) begin
                if (m_lock_cnt == 0) m_lock_cnt = 7'(LOCK_CYC);
                else if (m_lock_cnt <= 1) begin
                    m_lock_cnt = '0; m_locked = 1'b1;
                end else m_lock_cnt--;
            end
        end else begin
            m_locked = 1'b0; m_lock_cnt = '0;
        end
        cs = m_ctl[1] & m_cs_mask;
        if (cs == 0 || cs > 5) return;
        case (cs)
            1: divisor = 1;
            2: divisor = 8;
            3: divisor = 64;
            4: divisor = 256;
            default: divisor = 1024;
        endcase
        steps = int'(m_pre) + (m_pll[2] ? 8 : 1);
        m_pre = 11'(steps % divisor);
        steps = steps / divisor;
        repeat (steps) step_counter();
    endfunction

    function automatic logic [7:0] read_reg(reg_idx_t idx);
        case (idx)
            REG_CNT: return m_cnt[7:0];
            REG_HIGH: return {6'd0, m_hi};
            REG_OCRA, REG_OCRB, REG_OCRC, REG_OCRD:
                return m_cmp_buf[idx - REG_OCRA][7:0];
            REG_CTLA, REG_CTLB, REG_CTLC, REG_CTLD, REG_CTLE:
                return m_ctl[idx - REG_CTLA];
            REG_DT: return m_dt;
            REG_MASK: return m_mask;
            REG_FLAGS: return m_flags;
            REG_PLL: begin
                // status read shortens a running lock delay
                if (m_lock_cnt > 0 && !m_locked) begin
                    if (m_lock_cnt <= 5) begin
                        m_lock_cnt = '0; m_locked = 1'b1;
                    end else m_lock_cnt -= 7'd5;
                end
                return (m_pll & PLL_READ_MASK) | {7'd0, m_locked};
            end
            default: return 8'd0;
        endcase
    endfunction

    function automatic void write_reg(reg_idx_t idx, logic [7:0] v);
        logic [9:0] wide;
        int k;
        bit direct;
        wide = {m_hi, v};
        case (idx)
            REG_CNT: m_cnt = wide;
            REG_HIGH: m_hi = v[1:0];
            REG_OCRA, REG_OCRB, REG_OCRC, REG_OCRD: begin
                k = idx - REG_OCRA;
                m_cmp_buf[k] = wide;
                if (k == 2) direct = 1'b1;
                else if (k == 3) direct = (m_ctl[3][1:0] == 2'd0);
                else direct = (m_ctl[0][1:0] == 2'd0);
                if (direct) m_cmp_act[k] = wide;
            end
            REG_CTLA, REG_CTLB, REG_CTLC, REG_CTLD, REG_CTLE: m_ctl[idx - REG_CTLA] = v;
            REG_DT: m_dt = v;
            REG_MASK: m_mask = v;
            REG_FLAGS: m_flags &= ~v;
            REG_PLL: begin
                m_pll = v;
                if (v[1]) begin
                    if (!m_locked && m_lock_cnt == 0) m_lock_cnt = 7'(LOCK_CYC);
                end else begin
                    m_locked = 1'b0; m_lock_cnt = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic res_t predict_result(txn_t t);
        res_t r;
        logic [7:0] act;
        m_trig = '0;
        r = '0;
        case (t.action)
            ACT_TICK: if (!t.pd) cpu_tick();
            ACT_READ: r.rdata = read_reg(t.idx);
            ACT_WRITE: write_reg(t.idx, t.wdata);
            default: begin
                case (t.ack)
                    2'd0: m_flags &= ~FLAG_A;
                    2'd1: m_flags &= ~FLAG_B;
                    2'd2: m_flags &= ~FLAG_D;
                    default: m_flags &= ~FLAG_OVF;
                endcase
            end
        endcase
        // priority: compare A, B, D, then overflow
        act = m_flags & m_mask;
        if (act & FLAG_A) begin r.pend = 1'b1; r.src = 2'd0; end
        else if (act & FLAG_B) begin r.pend = 1'b1; r.src = 2'd1; end
        else if (act & FLAG_D) begin r.pend = 1'b1; r.src = 2'd2; end
        else if (act & FLAG_OVF) begin r.pend = 1'b1; r.src = 2'd3; end
        r.pins = m_pins;
        r.trig = m_trig;
        return r;
    endfunction

    // ---------------- stimulus queue and driver ----------------
    txn_t pending_q [$];

    function automatic txn_t make_txn(action_t a, reg_idx_t idx, logic [7:0] d,
                                      logic [1:0] ack, logic pd);
        txn_t t;
        t.action = a; t.idx = idx; t.wdata = d; t.ack = ack; t.pd = pd;
        return t;
    endfunction

    function automatic txn_t rand_txn();
        txn_t t;
        int sel;
        t.idx = reg_idx_t'($urandom_range(0, 15));
        t.wdata = 8'($urandom);
        t.ack = 2'($urandom);
        t.pd = ($urandom_range(0, 19) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 60) t.action = ACT_TICK;
        else if (sel < 75) t.action = ACT_READ;
        else if (sel < 93) t.action = ACT_WRITE;
        else t.action = ACT_ACK;
        // keep the period short most of the time so matches happen often
        if (t.action == ACT_WRITE && t.idx == REG_HIGH && $urandom_range(0, 3) != 0)
            t.wdata = 8'($urandom_range(0, 1)) | (t.wdata & 8'hFC);
        if (t.action == ACT_WRITE && t.idx == REG_CTLB && $urandom_range(0, 2) != 0)
            t.wdata = (t.wdata & 8'hF8) | 8'($urandom_range(1, 2));
        return t;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold the transaction until it is taken
        end else if (!hold_send && pending_q.size() > 0 &&
                     $urandom_range(0, 99) >= send_idle_pct) begin
            txn_t t;
            t = pending_q.pop_front();
            expected_q.push_back(predict_result(t));
            s_valid <= 1'b1;
            s_action <= t.action;
            s_reg_index <= t.idx;
            s_write_data <= t.wdata;
            s_ack_source <= t.ack;
            s_powered_down <= t.pd;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if ((s_valid && s_ready) || (m_valid && m_ready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (m_valid && m_ready) begin
                res_t got, exp_r;
                got = {m_rdata, m_pin_levels, m_irq_pending, m_irq_source,
                       m_adc_triggers};
                if (expected_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result %h", $time, got);
                end else begin
                    exp_r = expected_q.pop_front();
                    n_checked++;
                    if (got.rdata !== exp_r.rdata)
                        $display("%0t: rdata exp %h got %h", $time, exp_r.rdata, got.rdata);
                    if (got.pins !== exp_r.pins)
                        $display("%0t: pin_levels exp %h got %h", $time, exp_r.pins, got.pins);
                    if (got.pend !== exp_r.pend)
                        $display("%0t: irq_pending exp %b got %b", $time, exp_r.pend, got.pend);
                    if (got.src !== exp_r.src)
                        $display("%0t: irq_source exp %0d got %0d", $time, exp_r.src, got.src);
                    if (got.trig !== exp_r.trig)
                        $display("%0t: adc_triggers exp %h got %h", $time, exp_r.trig, got.trig);
                    if (got !== exp_r) n_fail++;
                end
            end
            if (wdog >= WDOG_MAX) begin
                $display("%0t: watchdog, nothing accepted for %0d cycles", $time, WDOG_MAX);
                $display("FAIL pwm_timer_with_dead_time");
                $finish;
            end
        end
    end

    // ---------------- sequencing ----------------
    task automatic wait_drained();
        while (pending_q.size() > 0 || s_valid || expected_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_mask(logic [7:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        m_cs_mask = v;
    endtask

    task automatic push_w(reg_idx_t idx, logic [7:0] d);
        pending_q.push_back(make_txn(ACT_WRITE, idx, d, 2'd0, 1'b0));
    endtask

    task automatic push_random(int n);
        repeat (n) pending_q.push_back(rand_txn());
    endtask

    // a well-formed pwm setup with random content
    task automatic push_setup();
        push_w(REG_HIGH, 8'd0);
        push_w(REG_OCRC, 8'($urandom_range(4, 40)));
        push_w(REG_OCRA, 8'($urandom_range(0, 40)));
        push_w(REG_OCRB, 8'($urandom_range(0, 40)));
        push_w(REG_OCRD, 8'($urandom_range(0, 40)));
        push_w(REG_CTLA, 8'($urandom));
        push_w(REG_CTLD, 8'($urandom));
        push_w(REG_DT, 8'($urandom));
        push_w(REG_MASK, 8'($urandom));
        push_w(REG_PLL, 8'($urandom_range(0, 7)));
        push_w(REG_CTLB, 8'($urandom_range(1, 3)));
    endtask

    initial begin
        timer_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every action, unused index, pll read, pll clock
        push_w(REG_NONE, 8'hFF);
        pending_q.push_back(make_txn(ACT_READ, REG_NONE, 8'h00, 2'd0, 1'b0));
        push_w(REG_HIGH, 8'hFF);
        push_w(REG_OCRC, 8'hFF);
        push_w(REG_HIGH, 8'h00);
        push_w(REG_OCRA, 8'h05);
        push_w(REG_OCRB, 8'h00);
        push_w(REG_OCRD, 8'h08);
        push_w(REG_CTLA, 8'hB3);
        push_w(REG_CTLD, 8'h30);
        push_w(REG_DT, 8'h00);
        push_w(REG_MASK, 8'hFF);
        push_w(REG_PLL, 8'h06);
        pending_q.push_back(make_txn(ACT_READ, REG_PLL, 8'h00, 2'd0, 1'b0));
        push_w(REG_CTLB, 8'h01);
        repeat (4) pending_q.push_back(make_txn(ACT_TICK, REG_CNT, 8'h00, 2'd0, 1'b0));
        pending_q.push_back(make_txn(ACT_TICK, REG_CNT, 8'h00, 2'd0, 1'b1));
        for (int a = 0; a < 4; a++)
            pending_q.push_back(make_txn(ACT_ACK, REG_CNT, 8'h00, 2'(a), 1'b0));
        push_w(REG_FLAGS, 8'hFF);
        pending_q.push_back(make_txn(ACT_READ, REG_CNT, 8'h00, 2'd3, 1'b0));
        wait_drained();

        // four idling phases, each with its own clock select mask
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; set_mask(8'hFF); end
                1: begin send_idle_pct = 73; recv_stall_pct = 0; set_mask(8'h00); end
                2: begin send_idle_pct = 0; recv_stall_pct = 73; set_mask(8'h07); end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; set_mask(8'h0F); end
            endcase
            repeat (9) begin
                push_setup();
                push_random(37);
            end
            if (ph == 1) begin
                // sender holds off until every outstanding result is back
                while (pending_q.size() > 0 || s_valid) @(posedge aclk);
                hold_send = 1'b1;
                while (expected_q.size() > 0) @(posedge aclk);
                hold_send = 1'b0;
                push_random(20);
            end
            wait_drained();
        end

        $display("checked %0d result transactions over four idling phases", n_checked);
        $display("mask settings 0xFF, 0x00, 0x07, 0x0F; directed plus random traffic");
        if (n_fail == 0) begin
            $display("PASS pwm_timer_with_dead_time");
        end else begin
            $display("FAIL pwm_timer_with_dead_time");
        end
        $finish;
    end
endmodule

FILE: filelist.f
sv/pwmt_pkg.sv
sv/pwmt_ctrl.sv
sv/pwmt_dp.sv
sv/pwm_timer_with_dead_time.sv
bench/pwm_timer_with_dead_time_tb.sv
